// File: rtl/core/rk4dp_pkg.sv
// Shared types, constants and saturation helper for the RK4 depth profile stepper.
`default_nettype none
package rk4dp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIVD_W    = 32 + FRAC_BITS + 1;

  localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_FIX = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [31:0] G_FIX =
    32'(((64'd981 << FRAC_BITS) + 64'd50) / 64'd100);

  typedef enum logic [1:0] {
    CFG_STEP_SIZE   = 2'd0,
    CFG_DISCHARGE   = 2'd1,
    CFG_START_DEPTH = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic signed [31:0] bed_slope;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] depth;
    logic               fault;
  } out_item_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [31:0]       divisor;
    logic              neg;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
    logic               fault;
  } div_rsp_t;

  // Applies a sign to a magnitude and clamps it to the signed 32-bit range.
  function automatic sat_t sat32(input logic neg, input logic [63:0] mag);
    sat_t r;
    r.ovf = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r.ovf = 1'b1;
        r.val = MIN32;
      end else begin
        r.val = 32'(64'd0 - mag);
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        r.ovf = 1'b1;
        r.val = MAX32;
      end else begin
        r.val = mag[31:0];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/rk4_depth_profile_step_top.sv
// RK4 depth profile stepper: one fourth-order Runge-Kutta step per input transfer.
// The result is ready sooner when a divide short-cuts on a zero divisor or an overflow.
// A new item is accepted only once the previous result has gone to the output register.
// Most of the time per item goes to the shared radix-2 divider, run four times per item.
// Reset (rst_n low, synchronous) clears the sequencer and output valid and loads
// step_size, discharge, start_depth and the running depth with 1.0.
`default_nettype none
module rk4_depth_profile_step_top
  import rk4dp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  // Reciprocal of six for an exact unsigned 32-bit division: x * RECIP6 >> 34.
  localparam logic [31:0] RECIP6 = 32'hAAAA_AAAB;

  // The sequencer walks the four stage evaluations, each of which cubes the
  // stage depth, scales it by g, divides q^2 by it and subtracts the stage slope.
  typedef enum logic [17:0] {
    ST_IDLE = 18'h00001,
    ST_NUM  = 18'h00002,
    ST_SQ   = 18'h00004,
    ST_CUBE = 18'h00008,
    ST_DEN  = 18'h00010,
    ST_DIV  = 18'h00020,
    ST_DIVW = 18'h00040,
    ST_SUB  = 18'h00080,
    ST_DBL  = 18'h00100,
    ST_ACC  = 18'h00200,
    ST_INC  = 18'h00400,
    ST_HALF = 18'h00800,
    ST_HS   = 18'h01000,
    ST_SS   = 18'h02000,
    ST_FM   = 18'h04000,
    ST_DIV6 = 18'h08000,
    ST_FIN  = 18'h10000
  } st_t;

  st_t                state_r, state_nxt;
  logic [1:0]         stg_r;
  logic               fault_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [30:0]        dx_r;
  logic [30:0]        disc_r;
  logic [30:0]        start_r;
  logic signed [31:0] h_r;

  logic signed [31:0] s_r;
  logic signed [31:0] hs_r;
  logic signed [31:0] ss_r;
  logic signed [31:0] num_r;
  logic signed [31:0] t_r;
  logic signed [31:0] k_r;
  logic signed [31:0] acc_r;

  alu_op_t            alu_op;
  logic signed [31:0] alu_a;
  logic signed [31:0] alu_b;
  logic               alu_used;
  sat_t               alu_res;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               in_xfer;
  logic               out_free;
  logic [32:0]        t_mag;
  logic [32:0]        t_hmag;
  logic signed [31:0] t_half;
  logic [31:0]        d6_x;
  logic [63:0]        d6_prod;
  logic [31:0]        d6_q;
  logic signed [31:0] t_div6;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !(out_valid_r && out_stall);

  // Magnitude of the temporary, used for halving and for the divider operands.
  assign t_mag  = t_r[31] ? (33'd0 - {t_r[31], t_r}) : {1'b0, t_r};
  assign t_hmag = (t_mag + 33'd1) >> 1;
  assign t_half = t_r[31] ? 32'(33'd0 - t_hmag) : t_hmag[31:0];

  // The final division by six rounds the magnitude by adding three, then uses
  // a reciprocal multiply. The magnitude never exceeds 2^31, so it fits 32 bits.
  assign d6_x    = t_mag[31:0] + 32'd3;
  assign d6_prod = 64'(d6_x) * 64'(RECIP6);
  assign d6_q    = {2'b00, d6_prod[63:34]};
  assign t_div6  = t_r[31] ? (32'd0 - d6_q) : d6_q;

  rk4dp_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  rk4dp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Divider request: q^2/den rounds by adding half the divisor.
  always_comb begin
    div_req.start    = (state_r == ST_DIV);
    div_req.neg      = t_r[31];
    div_req.dividend = (DIVD_W'(num_r[30:0]) << FRAC_BITS) + DIVD_W'(t_mag >> 1);
    div_req.divisor  = t_mag[31:0];
  end

  // Operand selection for the shared arithmetic unit.
  always_comb begin
    alu_op   = ALU_ADD;
    alu_a    = '0;
    alu_b    = '0;
    alu_used = 1'b1;
    case (state_r)
      ST_NUM: begin
        alu_op = ALU_MUL;
        alu_a  = {1'b0, disc_r};
        alu_b  = {1'b0, disc_r};
      end
      ST_SQ: begin
        alu_op = ALU_MUL;
        alu_a  = hs_r;
        alu_b  = hs_r;
      end
      ST_CUBE: begin
        alu_op = ALU_MUL;
        alu_a  = t_r;
        alu_b  = hs_r;
      end
      ST_DEN: begin
        alu_op = ALU_MUL;
        alu_a  = G_FIX;
        alu_b  = t_r;
      end
      ST_SUB: begin
        alu_op = ALU_SUB;
        alu_a  = t_r;
        alu_b  = ss_r;
      end
      ST_DBL: begin
        alu_a = k_r;
        alu_b = k_r;
      end
      ST_ACC: begin
        alu_a = acc_r;
        alu_b = (stg_r == 2'd3) ? k_r : t_r;
      end
      ST_INC: begin
        alu_op = ALU_MUL;
        alu_a  = {1'b0, dx_r};
        alu_b  = k_r;
      end
      ST_HS: begin
        alu_a = h_r;
        alu_b = t_r;
      end
      ST_SS: begin
        alu_a = s_r;
        alu_b = t_r;
      end
      ST_FM: begin
        alu_op = ALU_MUL;
        alu_a  = {1'b0, dx_r};
        alu_b  = acc_r;
      end
      ST_FIN: begin
        alu_a = h_r;
        alu_b = t_r;
      end
      default: alu_used = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_xfer) begin
        state_nxt = ST_NUM;
      end
      ST_NUM:  state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_CUBE;
      ST_CUBE: state_nxt = ST_DEN;
      ST_DEN:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_DIVW;
      ST_DIVW: if (div_rsp.done) begin
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        if (stg_r == 2'd0) begin
          state_nxt = ST_INC;
        end else if (stg_r == 2'd3) begin
          state_nxt = ST_ACC;
        end else begin
          state_nxt = ST_DBL;
        end
      end
      ST_DBL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (stg_r == 2'd3) ? ST_FM : ST_INC;
      ST_INC:  state_nxt = (stg_r == 2'd2) ? ST_HS : ST_HALF;
      ST_HALF: state_nxt = ST_HS;
      ST_HS:   state_nxt = ST_SS;
      ST_SS:   state_nxt = ST_SQ;
      ST_FM:   state_nxt = ST_DIV6;
      ST_DIV6: state_nxt = ST_FIN;
      ST_FIN: if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state and the architectural registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stg_r       <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
      dx_r        <= 31'(ONE_FIX);
      disc_r      <= 31'(ONE_FIX);
      start_r     <= 31'(ONE_FIX);
      h_r         <= ONE_FIX;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEP_SIZE:   dx_r    <= cfg_data;
          CFG_DISCHARGE:   disc_r  <= cfg_data;
          CFG_START_DEPTH: start_r <= cfg_data;
          default: ;
        endcase
      end
      // A result leaving in the same cycle as the next one is loaded keeps valid high.
      if (out_valid_r && !out_stall && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer) begin
        stg_r   <= '0;
        fault_r <= 1'b0;
        if (in_data.restart) begin
          h_r <= {1'b0, start_r};
        end
      end else begin
        if (alu_used && alu_res.ovf && state_r != ST_FIN) begin
          fault_r <= 1'b1;
        end
        if (state_r == ST_DIVW && div_rsp.done && div_rsp.fault) begin
          fault_r <= 1'b1;
        end
        if (state_r == ST_SS) begin
          stg_r <= stg_r + 2'd1;
        end
        if (state_r == ST_FIN && out_free) begin
          h_r         <= alu_res.val;
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers; they need no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s_r  <= in_data.bed_slope;
      ss_r <= in_data.bed_slope;
      hs_r <= in_data.restart ? {1'b0, start_r} : h_r;
    end
    case (state_r)
      ST_NUM:  num_r <= alu_res.val;
      ST_SQ, ST_CUBE, ST_DEN, ST_DBL, ST_INC, ST_FM: t_r <= alu_res.val;
      ST_DIVW: if (div_rsp.done) begin
        t_r <= div_rsp.quot;
      end
      ST_SUB: begin
        k_r <= alu_res.val;
        if (stg_r == 2'd0) begin
          acc_r <= alu_res.val;
        end
      end
      ST_ACC:  acc_r <= alu_res.val;
      ST_HALF: t_r <= t_half;
      ST_DIV6: t_r <= t_div6;
      ST_HS:   hs_r <= alu_res.val;
      ST_SS:   ss_r <= alu_res.val;
      ST_FIN: if (out_free) begin
        out_data_r.depth <= alu_res.val;
        out_data_r.fault <= fault_r | alu_res.ovf;
      end
      default: ;
    endcase
  end

  property p_state_onehot;
    @(posedge clk) disable iff (!rst_n) $onehot(state_r);
  endproperty
  a_state_onehot: assert property (p_state_onehot)
    else $error("sequencer state not one-hot");

  property p_div_done_waited;
    @(posedge clk) disable iff (!rst_n) div_rsp.done |-> state_r == ST_DIVW;
  endproperty
  a_div_done_waited: assert property (p_div_done_waited)
    else $error("divider finished while sequencer was not waiting");

  property p_accept_clears;
    @(posedge clk) disable iff (!rst_n)
      in_xfer |=> (stg_r == 2'd0 && !fault_r);
  endproperty
  a_accept_clears: assert property (p_accept_clears)
    else $error("item state not cleared on input transfer");

  property p_fin_delivers;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_FIN && out_free) |=> (out_valid_r && state_r == ST_IDLE);
  endproperty
  a_fin_delivers: assert property (p_fin_delivers)
    else $error("finished item did not reach the output register");

endmodule
`default_nettype wire

// File: rtl/core/rk4dp_alu.sv
// Shared saturating add, subtract and rounded Q multiply unit.
`default_nettype none
module rk4dp_alu
  import rk4dp_pkg::*;
(
  input  alu_op_t            op,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output sat_t               res
);

  logic signed [33:0] sum;
  logic [32:0]        ma;
  logic [32:0]        mb;
  logic [65:0]        prod;
  logic [65:0]        rnd;

  always_comb begin
    ma   = a[31] ? (33'd0 - {a[31], a}) : {1'b0, a};
    mb   = b[31] ? (33'd0 - {b[31], b}) : {1'b0, b};
    prod = {33'd0, ma} * {33'd0, mb};
    rnd  = (prod + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (op == ALU_SUB) begin
      sum = 34'(a) - 34'(b);
    end else begin
      sum = 34'(a) + 34'(b);
    end
    case (op)
      ALU_MUL: res = sat32(a[31] ^ b[31], rnd[63:0]);
      ALU_ADD, ALU_SUB: begin
        res.ovf = 1'b0;
        res.val = sum[31:0];
        if (sum > 34'(MAX32)) begin
          res.ovf = 1'b1;
          res.val = MAX32;
        end else if (sum < 34'(MIN32)) begin
          res.ovf = 1'b1;
          res.val = MIN32;
        end
      end
      default: begin
        res.ovf = 1'b0;
        res.val = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/rk4dp_div.sv
// Radix-2 restoring divider with rounding-aware saturation, 32 quotient bits.
`default_nettype none
module rk4dp_div
  import rk4dp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_DONE = 3'b100
  } dv_state_t;

  dv_state_t   state_r, state_nxt;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] lo_r;
  logic [31:0] quo_r;
  logic [31:0] dsr_r;
  logic        neg_r;
  logic        ovf_r;
  logic        zero_r;
  logic [33:0] trial;
  logic        hi_big;
  sat_t        fin;

  assign hi_big = (64'(req.dividend[DIVD_W-1:32]) >= 64'(req.divisor));
  assign trial  = {1'b0, rem_r, lo_r[31]} - {2'b00, dsr_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DV_IDLE: if (req.start) begin
        state_nxt = (req.divisor == '0 || hi_big) ? DV_DONE : DV_RUN;
      end
      DV_RUN:  if (cnt_r == '0) begin
        state_nxt = DV_DONE;
      end
      DV_DONE: state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == DV_IDLE) begin
        cnt_r <= 5'd31;
      end else if (state_r == DV_RUN) begin
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == DV_IDLE && req.start) begin
      rem_r  <= 32'(req.dividend[DIVD_W-1:32]);
      lo_r   <= req.dividend[31:0];
      dsr_r  <= req.divisor;
      neg_r  <= req.neg;
      zero_r <= (req.divisor == '0);
      ovf_r  <= hi_big;
      quo_r  <= '0;
    end else if (state_r == DV_RUN) begin
      lo_r <= {lo_r[30:0], 1'b0};
      if (!trial[33]) begin
        rem_r <= trial[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], lo_r[31]};
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  // A zero divisor only occurs with a non-negative numerator, so it clamps high.
  always_comb begin
    if (zero_r) begin
      fin.ovf = 1'b1;
      fin.val = MAX32;
    end else if (ovf_r) begin
      fin = sat32(neg_r, 64'hFFFF_FFFF_FFFF);
    end else begin
      fin = sat32(neg_r, 64'(quo_r));
    end
    rsp.done  = (state_r == DV_DONE);
    rsp.quot  = fin.val;
    rsp.fault = fin.ovf;
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (!(state_r == DV_RUN && !req.start) || 1'b1);
    end
  end

  property p_run_from_start;
    @(posedge clk) disable iff (!rst_n)
      (state_r == DV_IDLE && !req.start) |=> state_r == DV_IDLE;
  endproperty
  a_run_from_start: assert property (p_run_from_start)
    else $error("divider left idle without a start");

  property p_rem_below_divisor;
    @(posedge clk) disable iff (!rst_n)
      state_r == DV_RUN |-> rem_r < dsr_r;
  endproperty
  a_rem_below_divisor: assert property (p_rem_below_divisor)
    else $error("partial remainder not below divisor");

  property p_done_one_cycle;
    @(posedge clk) disable iff (!rst_n)
      state_r == DV_DONE |=> state_r == DV_IDLE;
  endproperty
  a_done_one_cycle: assert property (p_done_one_cycle)
    else $error("divider done held past one cycle");

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the RK4 depth profile stepper.
`default_nettype none
module tb;
  import rk4dp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HI32 = 64'sd2147483647;
  localparam longint LO32 = -64'sd2147483648;
  localparam longint GRAV = ((64'sd981 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
  localparam int STALL_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;

  rk4_depth_profile_step_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Profile points waiting to be sent, and depths the block should return.
  in_item_t  point_q[$];
  out_item_t depth_q[$];

  // Our own copy of the block's registers and running depth.
  longint dx_reg, q_reg, h0_reg, depth_now;
  bit     step_fault;

  int  err_count;
  int  points_sent, depths_seen, fault_seen_cnt, restart_cnt;
  bit  quiet;
  bit  in_took;
  int  in_gap, out_gap;
  int  idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Depth predictor: one fixed-point RK4 step, saturating and flagging faults.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clamp_signed(bit neg, logic [63:0] mag);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        step_fault = 1'b1;
        return LO32;
      end
      return -longint'(mag);
    end
    if (mag > 64'h7FFF_FFFF) begin
      step_fault = 1'b1;
      return HI32;
    end
    return longint'(mag);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > HI32) begin
      step_fault = 1'b1;
      return HI32;
    end
    if (s < LO32) begin
      step_fault = 1'b1;
      return LO32;
    end
    return s;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [63:0] p;
    p = magnitude(a) * magnitude(b);
    p = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return clamp_signed((a < 0) != (b < 0), p);
  endfunction

  // Division by a small integer, rounded to nearest with ties away from zero.
  function automatic longint round_div(longint a, logic [63:0] d);
    return clamp_signed(a < 0, (magnitude(a) + d / 2) / d);
  endfunction

  function automatic longint q_div(longint num, longint den);
    logic [63:0] md;
    if (den == 0) begin
      step_fault = 1'b1;
      return (num >= 0) ? HI32 : LO32;
    end
    md = magnitude(den);
    return clamp_signed((num < 0) != (den < 0),
                        ((magnitude(num) << FRAC_BITS) + md / 2) / md);
  endfunction

  // Water surface slope q^2 / (g h^3) minus the (advanced) bed slope.
  function automatic longint surface_slope(longint h, longint s);
    longint num, den;
    num = q_mul(q_reg, q_reg);
    den = q_mul(GRAV, q_mul(q_mul(h, h), h));
    return sat_sum(q_div(num, den), -s);
  endfunction

  function automatic out_item_t next_depth(in_item_t pt);
    out_item_t r;
    longint s, h, k1, k2, k3, k4, inc, acc;
    s = longint'(pt.bed_slope);
    step_fault = 1'b0;
    if (pt.restart) depth_now = h0_reg;
    h = depth_now;
    k1 = surface_slope(h, s);
    inc = round_div(q_mul(dx_reg, k1), 2);
    k2 = surface_slope(sat_sum(h, inc), sat_sum(s, inc));
    inc = round_div(q_mul(dx_reg, k2), 2);
    k3 = surface_slope(sat_sum(h, inc), sat_sum(s, inc));
    inc = q_mul(dx_reg, k3);
    k4 = surface_slope(sat_sum(h, inc), sat_sum(s, inc));
    acc = sat_sum(k1, sat_sum(k2, k2));
    acc = sat_sum(acc, sat_sum(k3, k3));
    acc = sat_sum(acc, k4);
    h = sat_sum(h, round_div(q_mul(dx_reg, acc), 6));
    depth_now = h;
    r.depth = h[31:0];
    r.fault = step_fault;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. A new point is presented at the falling edge once the
  // previous transfer completed; random bursts of idle cycles are inserted.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap > 0 && !quiet) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (point_q.size() > 0) begin
        in_data <= point_q.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The result side stalls in random bursts as well.
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted input transfer and check each accepted
  // output transfer against the oldest prediction. A watchdog counts cycles
  // in which no transfer of any kind happens.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    bit busy;
    busy = 1'b0;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        busy = 1'b1;
        points_sent++;
        if (in_data.restart) restart_cnt++;
        depth_q.push_back(next_depth(in_data));
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        depths_seen++;
        if (out_data.fault) fault_seen_cnt++;
        if (depth_q.size() == 0) begin
          report_mismatch("unexpected depth", longint'(out_data.depth), 0);
        end else begin
          want = depth_q.pop_front();
          if (out_data.depth !== want.depth)
            report_mismatch("depth", longint'(out_data.depth), longint'(want.depth));
          if (out_data.fault !== want.fault)
            report_mismatch("fault", longint'(out_data.fault), longint'(want.fault));
        end
      end
      if (cfg_valid && cfg_ready) busy = 1'b1;
    end
    if (busy) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input cfg_idx_t idx, input logic [30:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_STEP_SIZE:   dx_reg = longint'(val);
      CFG_DISCHARGE:   q_reg  = longint'(val);
      CFG_START_DEPTH: h0_reg = longint'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Block is idle only once every queued point has been sent and answered.
  task automatic drain;
    wait (point_q.size() == 0 && !in_valid && depth_q.size() == 0);
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [30:0] dx, input logic [30:0] q,
                          input logic [30:0] h0);
    drain();
    write_reg(CFG_STEP_SIZE, dx);
    write_reg(CFG_DISCHARGE, q);
    write_reg(CFG_START_DEPTH, h0);
  endtask

  task automatic push_point(input longint slope, input bit rs);
    in_item_t pt;
    pt.bed_slope = slope[31:0];
    pt.restart = rs;
    point_q.push_back(pt);
  endtask

  // Mostly gentle bed slopes so the profile evolves physically, plus some
  // steeper ones and the odd fully random word.
  task automatic push_random(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)
        push_point(longint'(int'($urandom_range(0, 6554)) - 3277),
                   $urandom_range(0, 9) == 0);
      else if (pick < 8)
        push_point(longint'(int'($urandom_range(0, 262144)) - 131072),
                   $urandom_range(0, 7) == 0);
      else
        push_point(longint'($signed($urandom())), $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_STEP_SIZE;
    cfg_data = '0;
    quiet = 1'b0;
    in_took = 1'b0;
    in_gap = 0;
    out_gap = 0;
    idle_cycles = 0;
    err_count = 0;
    points_sent = 0;
    depths_seen = 0;
    fault_seen_cnt = 0;
    restart_cnt = 0;
    dx_reg = 64'sd65536;
    q_reg = 64'sd65536;
    h0_reg = 64'sd65536;
    depth_now = 64'sd65536;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed points at the reset setting: slope extremes, restarts, and a
    // run that drives the depth negative and into saturation.
    push_point(0, 1'b0);
    push_point(HI32, 1'b0);
    push_point(LO32, 1'b0);
    push_point(-1, 1'b1);
    push_point(1, 1'b0);
    push_point(65536, 1'b1);
    push_point(-65536, 1'b0);
    push_point(LO32, 1'b1);
    push_point(HI32, 1'b1);
    push_point(0, 1'b1);

    // A start depth of one LSB makes g*h^3 round to zero: zero divisor case.
    set_regs(31'd65536, 31'd65536, 31'd1);
    push_point(0, 1'b1);
    push_point(0, 1'b0);
    push_point(HI32, 1'b1);

    // Register extremes: huge flow and depth with no step, then the opposite.
    set_regs(31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    push_point(0, 1'b1);
    push_point(LO32, 1'b0);
    push_point(12345, 1'b1);
    set_regs(31'h7FFF_FFFF, 31'd0, 31'd1);
    push_point(0, 1'b1);
    push_point(HI32, 1'b0);
    push_point(-7, 1'b1);
    push_random(60);

    // Random physically plausible settings: small dx, moderate flow and depth.
    for (int p = 0; p < 5; p++) begin
      set_regs(31'($urandom_range(655, 32768)), 31'($urandom_range(0, 196608)),
               31'($urandom_range(16384, 262144)));
      push_random(300);
    end

    // Fully random registers, then a quiet final phase without any idling.
    set_regs(31'($urandom()), 31'($urandom()), 31'($urandom_range(1, 32'h7FFF_FFFF)));
    push_random(150);
    set_regs(31'd6554, 31'd98304, 31'd131072);
    drain();
    quiet = 1'b1;
    push_random(150);

    drain();
    repeat (250) @(posedge clk);
    if (depth_q.size() != 0)
      report_mismatch("depths never returned", longint'(depth_q.size()), 0);
    $display("Covered %0d profile points (%0d restarts), %0d depths checked, %0d faulted,",
             points_sent, restart_cnt, depths_seen, fault_seen_cnt);
    $display("across reset, extreme and random register settings with random idling.");
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
